[rtl/rxl_pkg.sv]
`default_nettype none
package rxl_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;
  localparam logic [6:0] MAX_RESULTS = 7'd64;

  localparam logic [2:0] CMD_PUSH  = 3'd0;
  localparam logic [2:0] CMD_POP   = 3'd1;
  localparam logic [2:0] CMD_LINE  = 3'd2;
  localparam logic [2:0] CMD_BLOCK = 3'd3;
  localparam logic [2:0] CMD_FLUSH = 3'd4;

  localparam int CFG_AW = 3;
  localparam logic REG_LINE_DELIMITER = 1'b0;
  localparam logic REG_MAX_LINE_CHARS = 1'b1;
  localparam logic [7:0] LINE_DELIMITER_RESET = 8'd10;
  localparam logic [5:0] MAX_LINE_CHARS_RESET = 6'd63;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_WAIT,
    ST_SCAN_CHK,
    ST_READ_WAIT,
    ST_EMIT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic latch;
    logic push;
    logic flush;
    logic fail;
    logic ok;
    logic start_pop;
    logic start_block;
    logic start_scan;
    logic scan_step;
    logic line_empty;
    logic line_emit;
    logic emit;
    logic result;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       full;
    logic       empty;
    logic       block_ok;
    logic       want_zero;
    logic       scan_hit;
    logic       scan_first;
    logic       scan_end;
    logic       emit_last;
    logic       out_free;
  } dp_status_t;

endpackage
`default_nettype wire

[rtl/rx_fifo_line_extractor.sv]
// push, flush and failed commands give their one item through the decode and result states
// pop and block read: each byte goes through the read-wait and emit states to the output register
// line read: the scan reads the store one byte at a time up to the stop, then emits likewise
// one command at a time; the next is accepted the cycle after its last item enters the
// output register
// synchronous active-low reset empties the buffer, clears overflow and restores the registers
`default_nettype none
module rx_fifo_line_extractor #(
  parameter int BUFFER_DEPTH = rxl_pkg::BUFFER_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [15:0]                in_tdata,  // rx_byte[7:0], block_count[14:8]
  input  wire logic [2:0]                 in_tuser,  // cmd
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // data_byte[7:0], success[8], overflow[9], fill_level[16:10]
  output logic [23:0]                     out_tdata,
  output logic                            out_tlast,
  output logic [0:0]                      out_tuser, // has_data
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [rxl_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]                cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  logic [7:0]          line_delimiter_r;
  logic [5:0]          max_line_chars_r;
  logic                cfg_wr;
  rxl_pkg::ctrl_cmd_t  cmd;
  rxl_pkg::dp_status_t status;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_delimiter_r <= rxl_pkg::LINE_DELIMITER_RESET;
      max_line_chars_r <= rxl_pkg::MAX_LINE_CHARS_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        rxl_pkg::REG_LINE_DELIMITER: line_delimiter_r <= cfg_pwdata[7:0];
        rxl_pkg::REG_MAX_LINE_CHARS: max_line_chars_r <= cfg_pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      rxl_pkg::REG_LINE_DELIMITER: cfg_prdata = {24'd0, line_delimiter_r};
      rxl_pkg::REG_MAX_LINE_CHARS: cfg_prdata = {26'd0, max_line_chars_r};
      default:                     cfg_prdata = 32'd0;
    endcase
  end

  rxl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  rxl_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .cmd            (cmd),
    .status         (status),
    .line_delimiter (line_delimiter_r),
    .max_line_chars (max_line_chars_r),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .out_tuser      (out_tuser)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[16:10] <= 7'(BUFFER_DEPTH)))
    else $error("fill level above buffer depth");

  a_nodata_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tlast && (out_tdata[7:0] == 8'd0)))
    else $error("item without data must be last and carry zero");

  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tdata[8])
    else $error("data item without success");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item taken while a command is in progress");

endmodule
`default_nettype wire

[rtl/rxl_ctrl.sv]
`default_nettype none
module rxl_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire rxl_pkg::dp_status_t  status,
  output rxl_pkg::ctrl_cmd_t        cmd
);

  rxl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rxl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      rxl_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = rxl_pkg::ST_DECODE;
        end
      end
      rxl_pkg::ST_DECODE: begin
        state_nxt = rxl_pkg::ST_RESULT;
        unique case (status.cmd)
          rxl_pkg::CMD_PUSH: cmd.push = 1'b1;
          rxl_pkg::CMD_POP: begin
            if (status.empty) begin
              cmd.fail = 1'b1;
            end else begin
              cmd.start_pop = 1'b1;
              state_nxt     = rxl_pkg::ST_READ_WAIT;
            end
          end
          rxl_pkg::CMD_LINE: begin
            if (status.empty) begin
              cmd.fail = 1'b1;
            end else begin
              cmd.start_scan = 1'b1;
              state_nxt      = rxl_pkg::ST_SCAN_WAIT;
            end
          end
          rxl_pkg::CMD_BLOCK: begin
            if (!status.block_ok) begin
              cmd.fail = 1'b1;
            end else if (status.want_zero) begin
              cmd.ok = 1'b1;
            end else begin
              cmd.start_block = 1'b1;
              state_nxt       = rxl_pkg::ST_READ_WAIT;
            end
          end
          rxl_pkg::CMD_FLUSH: cmd.flush = 1'b1;
          default: cmd.fail = 1'b1;
        endcase
      end
      rxl_pkg::ST_SCAN_WAIT: state_nxt = rxl_pkg::ST_SCAN_CHK;
      rxl_pkg::ST_SCAN_CHK: begin
        if (status.scan_hit) begin
          if (status.scan_first) begin
            cmd.line_empty = 1'b1;
            state_nxt      = rxl_pkg::ST_RESULT;
          end else begin
            cmd.line_emit = 1'b1;
            state_nxt     = rxl_pkg::ST_READ_WAIT;
          end
        end else if (status.scan_end) begin
          cmd.fail  = 1'b1;
          state_nxt = rxl_pkg::ST_RESULT;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt     = rxl_pkg::ST_SCAN_WAIT;
        end
      end
      rxl_pkg::ST_READ_WAIT: state_nxt = rxl_pkg::ST_EMIT;
      rxl_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = status.emit_last ? rxl_pkg::ST_IDLE : rxl_pkg::ST_READ_WAIT;
        end
      end
      rxl_pkg::ST_RESULT: begin
        if (status.out_free) begin
          cmd.result = 1'b1;
          state_nxt  = rxl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rxl_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/rxl_dp.sv]
`default_nettype none
module rxl_dp #(
  parameter int BUFFER_DEPTH = rxl_pkg::BUFFER_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [15:0]         in_tdata,
  input  wire logic [2:0]          in_tuser,
  input  wire rxl_pkg::ctrl_cmd_t  cmd,
  output rxl_pkg::dp_status_t      status,
  input  wire logic [7:0]          line_delimiter,
  input  wire logic [5:0]          max_line_chars,
  input  wire logic                out_tready,
  output logic                     out_tvalid,
  output logic [23:0]              out_tdata,
  output logic                     out_tlast,
  output logic [0:0]               out_tuser
);

  localparam int IW   = $clog2(BUFFER_DEPTH);
  localparam int CW   = $clog2(BUFFER_DEPTH + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;

  logic [7:0]      mem [BUFFER_DEPTH];
  logic [2:0]      cmd_r;
  logic [7:0]      rx_r;
  logic [6:0]      want_r;
  logic            ok_r;
  logic            ovf_r, ovf_nxt;
  logic [IW-1:0]   rd_r, rd_nxt;
  logic [IW-1:0]   wr_r, wr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [IW-1:0]   addr_r;
  logic [5:0]      scan_r;
  logic [6:0]      left_r;
  logic [7:0]      rdata_r;
  logic            out_valid_r;
  logic            out_has_r;
  logic [7:0]      out_data_r;
  logic            out_last_r;
  logic            out_ok_r;
  logic            out_ovf_r;
  logic [6:0]      out_fill_r;

  logic            full;
  logic            consume;
  logic [CMPW-1:0] take;
  logic [CMPW-1:0] cnt_x;
  logic [CMPW:0]   rd_sum;
  logic [CMPW:0]   rd_wrap;
  logic [IW-1:0]   addr_inc;
  logic [IW-1:0]   wr_inc;
  logic            out_free;

  assign full     = (count_r == CW'(BUFFER_DEPTH));
  assign cnt_x    = CMPW'(count_r);
  assign out_free = !out_valid_r || out_tready;
  assign addr_inc = (addr_r == IW'(BUFFER_DEPTH - 1)) ? '0 : addr_r + IW'(1);
  assign wr_inc   = (wr_r == IW'(BUFFER_DEPTH - 1)) ? '0 : wr_r + IW'(1);

  assign consume = cmd.start_pop | cmd.start_block | cmd.line_empty | cmd.line_emit;

  always_comb begin
    take = CMPW'(1);
    if (cmd.start_block) begin
      take = CMPW'(want_r);
    end else if (cmd.line_emit) begin
      take = CMPW'(scan_r) + CMPW'(1);
    end
  end

  // take never exceeds the fill, so one subtract wraps the read side
  assign rd_sum  = (CMPW + 1)'(rd_r) + (CMPW + 1)'(take);
  assign rd_wrap = (rd_sum >= (CMPW + 1)'(BUFFER_DEPTH)) ?
                   rd_sum - (CMPW + 1)'(BUFFER_DEPTH) : rd_sum;

  always_comb begin
    rd_nxt    = rd_r;
    wr_nxt    = wr_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (cmd.flush) begin
      rd_nxt    = '0;
      wr_nxt    = '0;
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (cmd.push) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        wr_nxt    = wr_inc;
        count_nxt = count_r + CW'(1);
      end
    end else if (consume) begin
      rd_nxt    = IW'(rd_wrap);
      count_nxt = CW'(cnt_x - take);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r        <= '0;
      wr_r        <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_r    <= rd_nxt;
      wr_r    <= wr_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      if (cmd.emit || cmd.result) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      mem[wr_r] <= rx_r;
    end
    rdata_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r  <= in_tuser;
      rx_r   <= in_tdata[7:0];
      want_r <= in_tdata[14:8];
    end
    if (cmd.push) begin
      ok_r <= !full;
    end else if (cmd.flush || cmd.ok || cmd.line_empty) begin
      ok_r <= 1'b1;
    end else if (cmd.fail) begin
      ok_r <= 1'b0;
    end
    if (cmd.start_pop || cmd.start_block || cmd.start_scan || cmd.line_emit) begin
      addr_r <= rd_r;
    end else if (cmd.scan_step || cmd.emit) begin
      addr_r <= addr_inc;
    end
    if (cmd.start_scan) begin
      scan_r <= '0;
    end else if (cmd.scan_step) begin
      scan_r <= scan_r + 6'd1;
    end
    if (cmd.start_pop) begin
      left_r <= 7'd1;
    end else if (cmd.start_block) begin
      left_r <= want_r;
    end else if (cmd.line_emit) begin
      left_r <= {1'b0, scan_r};
    end else if (cmd.emit) begin
      left_r <= left_r - 7'd1;
    end
    if (cmd.emit) begin
      out_has_r  <= 1'b1;
      out_data_r <= rdata_r;
      out_last_r <= (left_r == 7'd1);
      out_ok_r   <= 1'b1;
      out_ovf_r  <= ovf_r;
      out_fill_r <= 7'(count_r);
    end else if (cmd.result) begin
      out_has_r  <= 1'b0;
      out_data_r <= 8'd0;
      out_last_r <= 1'b1;
      out_ok_r   <= ok_r;
      out_ovf_r  <= ovf_r;
      out_fill_r <= 7'(count_r);
    end
  end

  always_comb begin
    status.cmd        = cmd_r;
    status.full       = full;
    status.empty      = (count_r == '0);
    status.block_ok   = (want_r <= rxl_pkg::MAX_RESULTS) && (CMPW'(want_r) <= cnt_x);
    status.want_zero  = (want_r == 7'd0);
    status.scan_hit   = (rdata_r == line_delimiter) || (scan_r == max_line_chars);
    status.scan_first = (scan_r == 6'd0);
    status.scan_end   = ((CMPW'(scan_r) + CMPW'(1)) == cnt_x);
    status.emit_last  = (left_r == 7'd1);
    status.out_free   = out_free;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_fill_r, out_ovf_r, out_ok_r, out_data_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_has_r;

endmodule
`default_nettype wire
